// ===== rtl/gzl_pkg.sv =====
// ----------------------------------------------------------------------------
// gzl_pkg: shared types and constants for the 3-D zone lookup
// Request codes, table selectors, register indexes, write commands and the
// result record used by the top level and the per-axis index unit.
// ----------------------------------------------------------------------------
package gzl_pkg;

    // default table sizes
    localparam int MAX_EDGES_DEF    = 64;
    localparam int CELL_ENTRIES_DEF = 1024;
    localparam int ZONE_ENTRIES_DEF = 4096;

    // fixed by the field widths
    localparam int MAX_ZONES           = 64;
    localparam int SCALE_FRACTION_BITS = 24;
    localparam int IV_W                = 7;   // interval, may reach 64
    localparam int PART_W              = 14;  // ix*ny+iy
    localparam int DENSE_W             = 20;  // (ix*ny+iy)*nz+iz

    // request kinds
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // table selectors
    localparam logic [1:0] TSEL_EDGE  = 2'd0;
    localparam logic [1:0] TSEL_CELL  = 2'd1;
    localparam logic [1:0] TSEL_ZONE  = 2'd2;
    localparam logic [1:0] TSEL_SCALE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_Z_LOW  = 3'd4;
    localparam logic [2:0] REG_Z_HIGH = 3'd5;
    localparam logic [2:0] REG_Y_IVS  = 3'd6;
    localparam logic [2:0] REG_Z_IVS  = 3'd7;

    typedef struct packed {
        logic        en;
        logic [1:0]  tsel;
        logic [11:0] addr;
        logic [31:0] data;
    } t_axis_wr;

    typedef struct packed {
        logic        en;
        logic [11:0] addr;
        logic [6:0]  data;
    } t_zone_wr;

    typedef struct packed {
        logic       found;
        logic [5:0] zone;
    } t_result;

endpackage

// ===== rtl/gzl_axis.sv =====
// ----------------------------------------------------------------------------
// gzl_axis: per-axis interval finder
// Offset from the lower bound, scale multiply, coarse cell table read, edge
// read and step-up compare over five register stages. Holds the axis scale,
// the coarse cell table and the edge table; table writes travel with the
// beats and land at the stage that reads that table.
// ----------------------------------------------------------------------------
module gzl_axis #(
    parameter int MAX_EDGES    = gzl_pkg::MAX_EDGES_DEF,
    parameter int CELL_ENTRIES = gzl_pkg::CELL_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [31:0]                 i_coord,
    input  logic [31:0]                 i_low,
    input  gzl_pkg::t_axis_wr           i_wr,
    output logic [gzl_pkg::IV_W-1:0]    o_interval
);

    localparam int EW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(CELL_ENTRIES);
    localparam int SFB = gzl_pkg::SCALE_FRACTION_BITS;
    localparam int HW  = 64 - SFB;

    gzl_pkg::t_axis_wr r_wr2, r_wr3, r_wr4;

    logic [31:0] r_off2, r_p2, r_p3, r_p4, r_p5;
    logic [31:0] r_scale;
    logic [63:0] r_prod3;
    logic [5:0]  r_cell4;
    logic [31:0] r_edge5;
    logic [5:0]  r_t5;
    logic [6:0]  r_next5;
    logic        r_ok5;
    logic [gzl_pkg::IV_W-1:0] r_iv6;

    logic [5:0]  cell_mem [CELL_ENTRIES];
    logic [31:0] edge_mem [MAX_EDGES];

    logic [31:0]   n_off;
    logic [63:0]   n_prod;
    logic [HW-1:0] hi;
    logic [CW-1:0] n_cell;
    logic [6:0]    n_next;
    logic          n_ok;
    logic [gzl_pkg::IV_W-1:0] n_iv;
    logic          cell_we, edge_we;

    assign n_off  = i_coord - i_low;
    assign n_prod = r_off2 * r_scale;
    assign hi     = r_prod3[63:SFB];
    // saturate past the last coarse cell
    assign n_cell = (hi > HW'(CELL_ENTRIES - 1)) ? CW'(CELL_ENTRIES - 1) : hi[CW-1:0];
    assign n_next = {1'b0, r_cell4} + 7'd1;
    assign n_ok   = 32'(n_next) < MAX_EDGES;
    assign n_iv   = (r_ok5 && ($signed(r_p5) > $signed(r_edge5)))
                  ? gzl_pkg::IV_W'(r_next5) : gzl_pkg::IV_W'(r_t5);

    assign cell_we = r_wr3.en && (r_wr3.tsel == gzl_pkg::TSEL_CELL)
                  && (32'(r_wr3.addr) < CELL_ENTRIES);
    assign edge_we = r_wr4.en && (r_wr4.tsel == gzl_pkg::TSEL_EDGE)
                  && (32'(r_wr4.addr) < MAX_EDGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr2.en <= 1'b0;
            r_wr3.en <= 1'b0;
            r_wr4.en <= 1'b0;
        end else if (i_en) begin
            r_wr2 <= i_wr;
            r_wr3 <= r_wr2;
            r_wr4 <= r_wr3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off2  <= n_off;
            r_p2    <= i_coord;
            r_prod3 <= n_prod;
            r_p3    <= r_p2;
            r_p4    <= r_p3;
            r_p5    <= r_p4;
            r_t5    <= r_cell4;
            r_next5 <= n_next;
            r_ok5   <= n_ok;
            r_iv6   <= n_iv;
            if (r_wr2.en && (r_wr2.tsel == gzl_pkg::TSEL_SCALE)) begin
                r_scale <= r_wr2.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (cell_we) begin
                cell_mem[CW'(r_wr3.addr)] <= r_wr3.data[5:0];
            end
            r_cell4 <= cell_mem[n_cell];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (edge_we) begin
                edge_mem[EW'(r_wr4.addr)] <= r_wr4.data;
            end
            r_edge5 <= edge_mem[EW'(n_next)];
        end
    end

    assign o_interval = r_iv6;

endmodule

// ===== rtl/grid_zone_lookup_3d.sv =====
// ----------------------------------------------------------------------------
// grid_zone_lookup_3d: zone lookup for a 3-D point in a gridded map
// Box check, per-axis cell and edge lookup, dense index and zone table read.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream beats carry either a zone query (tuser[0] = 0) with a point
//   in tdata, or a table write (tuser[0] = 1) that stores one word into the
//   edge, coarse cell, zone or axis scale table chosen by tuser. Queries
//   give one master beat each (found in tuser[0], zone in tdata); writes
//   give none. Writes and queries take effect in stream order.
//   The pipeline takes one beat per cycle while the skid buffer is empty.
//   Its depth comes from the scale multiply, the three table reads (coarse
//   cell, edge, zone) and the two multiply-add steps of the dense index.
//   A two-entry output register and skid buffer sit at the end: when the
//   receiver stalls, one more result is parked and then the whole pipeline
//   holds, dropping tready, without losing or repeating a beat.
//   Reset clears the pipeline valid bits, the output stage and the APB
//   registers (bounds 0, interval counts 1). The tables are not cleared and
//   must be loaded before a query reads them. The user makes APB writes only
//   while no query is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module grid_zone_lookup_3d #(
    parameter int MAX_EDGES    = gzl_pkg::MAX_EDGES_DEF,
    parameter int CELL_ENTRIES = gzl_pkg::CELL_ENTRIES_DEF,
    parameter int ZONE_ENTRIES = gzl_pkg::ZONE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_x, point_y, point_z, write_address, write_value, 4 zero bits
    input  logic [143:0] i_s_axis_tdata,
    // req_type, table_select, axis_select
    input  logic [4:0]   i_s_axis_tuser,
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // zone_index, 2 zero bits
    output logic [7:0]   o_m_axis_tdata,
    // found
    output logic [0:0]   o_m_axis_tuser,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ZW = (ZONE_ENTRIES > 1) ? $clog2(ZONE_ENTRIES) : 1;
    localparam int IVW = gzl_pkg::IV_W;

    // ---------------- configuration registers ----------------
    logic [31:0] r_low  [3];
    logic [31:0] r_high [3];
    logic [5:0]  r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_low[a]  <= '0;
                r_high[a] <= '0;
            end
            r_ny <= 6'd1;
            r_nz <= 6'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                gzl_pkg::REG_X_LOW:  r_low[0]  <= pwdata;
                gzl_pkg::REG_X_HIGH: r_high[0] <= pwdata;
                gzl_pkg::REG_Y_LOW:  r_low[1]  <= pwdata;
                gzl_pkg::REG_Y_HIGH: r_high[1] <= pwdata;
                gzl_pkg::REG_Z_LOW:  r_low[2]  <= pwdata;
                gzl_pkg::REG_Z_HIGH: r_high[2] <= pwdata;
                gzl_pkg::REG_Y_IVS:  r_ny      <= pwdata[5:0];
                gzl_pkg::REG_Z_IVS:  r_nz      <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gzl_pkg::REG_X_LOW:  prdata = r_low[0];
            gzl_pkg::REG_X_HIGH: prdata = r_high[0];
            gzl_pkg::REG_Y_LOW:  prdata = r_low[1];
            gzl_pkg::REG_Y_HIGH: prdata = r_high[1];
            gzl_pkg::REG_Z_LOW:  prdata = r_low[2];
            gzl_pkg::REG_Z_HIGH: prdata = r_high[2];
            gzl_pkg::REG_Y_IVS:  prdata = {26'd0, r_ny};
            gzl_pkg::REG_Z_IVS:  prdata = {26'd0, r_nz};
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipeline control ----------------
    logic en;
    logic r_skid_v, r_out_v;

    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;

    // ---------------- stage 1: accepted beat ----------------
    logic        r_v1;
    logic        r_req1;
    logic [1:0]  r_tsel1, r_axis1;
    logic [11:0] r_addr1;
    logic [31:0] r_data1;
    logic [31:0] r_p1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req1  <= i_s_axis_tuser[0];
            r_tsel1 <= i_s_axis_tuser[2:1];
            r_axis1 <= i_s_axis_tuser[4:3];
            r_p1[0] <= i_s_axis_tdata[31:0];
            r_p1[1] <= i_s_axis_tdata[63:32];
            r_p1[2] <= i_s_axis_tdata[95:64];
            r_addr1 <= i_s_axis_tdata[107:96];
            r_data1 <= i_s_axis_tdata[139:108];
        end
    end

    logic              qv1, wr1, inbox1;
    gzl_pkg::t_zone_wr zw1;

    assign qv1 = r_v1 && (r_req1 == gzl_pkg::REQ_QUERY);
    assign wr1 = r_v1 && (r_req1 == gzl_pkg::REQ_WRITE);

    always_comb begin
        inbox1 = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (($signed(r_p1[a]) < $signed(r_low[a])) ||
                ($signed(r_p1[a]) > $signed(r_high[a]))) begin
                inbox1 = 1'b0;
            end
        end
    end

    always_comb begin
        zw1.en   = wr1 && (r_tsel1 == gzl_pkg::TSEL_ZONE) && (32'(r_addr1) < ZONE_ENTRIES);
        zw1.addr = r_addr1;
        zw1.data = r_data1[6:0];
    end

    // ---------------- stages 2..6: per-axis interval ----------------
    logic [IVW-1:0] iv [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        gzl_pkg::t_axis_wr axw;

        always_comb begin
            axw.en   = wr1 && (r_tsel1 != gzl_pkg::TSEL_ZONE) && (r_axis1 == 2'(a));
            axw.tsel = r_tsel1;
            axw.addr = r_addr1;
            axw.data = r_data1;
        end

        gzl_axis #(
            .MAX_EDGES    (MAX_EDGES),
            .CELL_ENTRIES (CELL_ENTRIES)
        ) u_axis (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_coord    (r_p1[a]),
            .i_low      (r_low[a]),
            .i_wr       (axw),
            .o_interval (iv[a])
        );
    end

    // valid query and in-box flags ride along, stages 2..9
    logic [9:2] r_qv;
    logic [9:2] r_inb;
    gzl_pkg::t_zone_wr r_zw [2:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
            for (int k = 2; k <= 8; k++) begin
                r_zw[k].en <= 1'b0;
            end
        end else if (en) begin
            r_qv  <= {r_qv[8:2], qv1};
            r_zw[2] <= zw1;
            for (int k = 3; k <= 8; k++) begin
                r_zw[k] <= r_zw[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inb <= {r_inb[8:2], inbox1};
        end
    end

    // ---------------- stages 6..8: dense index ----------------
    logic [gzl_pkg::PART_W-1:0]  n_part, r_part7;
    logic [IVW-1:0]              r_iz7;
    logic [gzl_pkg::DENSE_W-1:0] n_dense, r_dense8;

    assign n_part  = gzl_pkg::PART_W'(gzl_pkg::PART_W'(iv[0]) * gzl_pkg::PART_W'(r_ny))
                   + gzl_pkg::PART_W'(iv[1]);
    assign n_dense = gzl_pkg::DENSE_W'(gzl_pkg::DENSE_W'(r_part7)
                   * gzl_pkg::DENSE_W'(r_nz)) + gzl_pkg::DENSE_W'(r_iz7);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_part7  <= n_part;
            r_iz7    <= iv[2];
            r_dense8 <= n_dense;
        end
    end

    // ---------------- stage 8: zone table ----------------
    logic [6:0] zone_mem [ZONE_ENTRIES];
    logic [6:0] r_zrd9;
    logic       r_zin9;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zw[8].en) begin
                zone_mem[ZW'(r_zw[8].addr)] <= r_zw[8].data;
            end
            r_zrd9 <= zone_mem[ZW'(r_dense8)];
            r_zin9 <= r_dense8 < gzl_pkg::DENSE_W'(ZONE_ENTRIES);
        end
    end

    // ---------------- stage 9: decode ----------------
    gzl_pkg::t_result res;
    logic             res_v;

    assign res_v = r_qv[9];

    always_comb begin
        res.found = r_inb[9] && r_zin9 && r_zrd9[6]
                 && (13'(r_zrd9[5:0]) < 13'(gzl_pkg::MAX_ZONES));
        res.zone  = res.found ? r_zrd9[5:0] : 6'd0;
    end

    // ---------------- output register and skid ----------------
    gzl_pkg::t_result r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= res_v;
                r_out   <= res;
            end
        end else if (res_v && !r_skid_v) begin
            // park the beat, pipeline holds next cycle
            r_skid   <= res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_m_axis_tvalid   = r_out_v;
    assign o_m_axis_tdata    = {2'b00, r_out.zone};
    assign o_m_axis_tuser[0] = r_out.found;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> o_m_axis_tvalid)
        else $error("skid holds a beat while the output register is empty");

    a_skid_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("skid loaded without a receiver stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_m_axis_tready) |=> (!r_skid_v && o_m_axis_tvalid))
        else $error("skid beat not moved to the output register");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the 3-D zone lookup
// Loads the reachable part of each table through write beats, then runs
// directed and random queries and table writes under several map settings
// and idle patterns. A predictor mirrors the tables and registers and checks
// each result beat.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_EDGES       = gzl_pkg::MAX_EDGES_DEF;
    localparam int N_CELLS       = gzl_pkg::CELL_ENTRIES_DEF;
    localparam int N_ZONES       = gzl_pkg::ZONE_ENTRIES_DEF;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 128;

    // random queries stay inside these loaded regions
    localparam int EDGES_USED = 8;
    localparam int CELLS_USED = 64;
    localparam int ZONES_USED = 512;
    // cells hold 0..3, the step-up adds one
    localparam int IV_REACH   = 4;
    // bound on (ny+1)*nz that keeps the dense index inside the loaded zones
    localparam int ZONE_PAIRS = ZONES_USED / IV_REACH - 2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [2:0] LOW_REG  [3] = '{gzl_pkg::REG_X_LOW, gzl_pkg::REG_Y_LOW,
                                            gzl_pkg::REG_Z_LOW};
    localparam logic [2:0] HIGH_REG [3] = '{gzl_pkg::REG_X_HIGH, gzl_pkg::REG_Y_HIGH,
                                            gzl_pkg::REG_Z_HIGH};
    localparam int SEND_IDLE  [4] = '{0, 78, 0, 12};
    localparam int RECV_STALL [4] = '{0, 0, 78, 12};

    typedef struct packed {
        logic        req;
        logic [1:0]  tsel;
        logic [1:0]  axis;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [11:0] addr;
        logic [31:0] wval;
    } t_lookup_req;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata = '0;
    logic [4:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    grid_zone_lookup_3d dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // mirror of the block's registers and tables
    logic [31:0] cfg_regs [8];
    logic [31:0] edge_tbl [3][N_EDGES];
    logic [5:0]  cell_tbl [3][N_CELLS];
    logic [6:0]  zone_tbl [N_ZONES];
    logic [31:0] scale_tbl [3];
    logic [31:0] scale_base [3];

    t_lookup_req      request_q [$];
    gzl_pkg::t_result zone_results_q [$];
    t_lookup_req      offered;
    int beats_pushed = 0;
    int beats_accepted = 0;
    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [6:0] lookup_interval(input int axis, input logic [31:0] p,
                                                   input logic [31:0] lo);
        logic [31:0] offset;
        logic [63:0] cell_idx;
        logic [6:0]  t;
        offset = p - lo;
        cell_idx = (64'(offset) * 64'(scale_tbl[axis])) >> gzl_pkg::SCALE_FRACTION_BITS;
        if (cell_idx > 64'(N_CELLS - 1)) begin
            cell_idx = 64'(N_CELLS - 1);
        end
        t = {1'b0, cell_tbl[axis][int'(cell_idx)]};
        // step up only while an upper edge exists in the table
        if (int'(t) + 1 < N_EDGES) begin
            if ($signed(p) > $signed(edge_tbl[axis][int'(t) + 1])) begin
                t = t + 7'd1;
            end
        end
        return t;
    endfunction

    function automatic logic in_span(input logic [31:0] p, input logic [2:0] lo_reg,
                                     input logic [2:0] hi_reg);
        return $signed(p) >= $signed(cfg_regs[lo_reg])
            && $signed(p) <= $signed(cfg_regs[hi_reg]);
    endfunction

    function automatic gzl_pkg::t_result predict_zone(input t_lookup_req r);
        gzl_pkg::t_result res;
        logic [6:0]  ix;
        logic [6:0]  iy;
        logic [6:0]  iz;
        logic [63:0] dense;
        logic [6:0]  entry;
        res = '0;
        if (in_span(r.px, gzl_pkg::REG_X_LOW, gzl_pkg::REG_X_HIGH)
            && in_span(r.py, gzl_pkg::REG_Y_LOW, gzl_pkg::REG_Y_HIGH)
            && in_span(r.pz, gzl_pkg::REG_Z_LOW, gzl_pkg::REG_Z_HIGH)) begin
            ix = lookup_interval(0, r.px, cfg_regs[gzl_pkg::REG_X_LOW]);
            iy = lookup_interval(1, r.py, cfg_regs[gzl_pkg::REG_Y_LOW]);
            iz = lookup_interval(2, r.pz, cfg_regs[gzl_pkg::REG_Z_LOW]);
            dense = (64'(ix) * 64'(cfg_regs[gzl_pkg::REG_Y_IVS]) + 64'(iy))
                    * 64'(cfg_regs[gzl_pkg::REG_Z_IVS]) + 64'(iz);
            if (dense < 64'(N_ZONES)) begin
                entry = zone_tbl[int'(dense)];
                if (entry[6] && int'(entry[5:0]) < gzl_pkg::MAX_ZONES) begin
                    res.found = 1'b1;
                    res.zone = entry[5:0];
                end
            end
        end
        return res;
    endfunction

    function automatic void store_table_word(input t_lookup_req r);
        if (r.tsel == gzl_pkg::TSEL_ZONE) begin
            if (int'(r.addr) < N_ZONES) begin
                zone_tbl[r.addr] = r.wval[6:0];
            end
        end else if (r.axis != AXIS_NONE) begin
            case (r.tsel)
                gzl_pkg::TSEL_EDGE: begin
                    if (int'(r.addr) < N_EDGES) begin
                        edge_tbl[r.axis][r.addr] = r.wval;
                    end
                end
                gzl_pkg::TSEL_CELL: begin
                    if (int'(r.addr) < N_CELLS) begin
                        cell_tbl[r.axis][r.addr] = r.wval[5:0];
                    end
                end
                default: begin
                    scale_tbl[r.axis] = r.wval;
                end
            endcase
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (offered.req == gzl_pkg::REQ_WRITE) begin
                    store_table_word(offered);
                end else begin
                    zone_results_q.insert(zone_results_q.size(), predict_zone(offered));
                end
                beats_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = request_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {4'b0, offered.wval, offered.addr,
                                       offered.pz, offered.py, offered.px};
                    i_s_axis_tuser <= {offered.axis, offered.tsel, offered.req};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_check
        gzl_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (zone_results_q.size() == 0) begin
                    $display("%0t: unexpected result beat, found %0d zone %0d",
                             $time, o_m_axis_tuser[0], o_m_axis_tdata[5:0]);
                    errors++;
                end else begin
                    want = zone_results_q.pop_front();
                    if (o_m_axis_tuser[0] !== want.found) begin
                        $display("%0t: found mismatch, expected %0d actual %0d",
                                 $time, want.found, o_m_axis_tuser[0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[5:0] !== want.zone) begin
                        $display("%0t: zone mismatch, expected %0d actual %0d",
                                 $time, want.zone, o_m_axis_tdata[5:0]);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (holds_served != holds_asked) begin
                // hold off long enough to back the pipeline up to its input
                holds_served++;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_regs[idx] = (idx == gzl_pkg::REG_Y_IVS || idx == gzl_pkg::REG_Z_IVS)
                      ? {26'b0, val[5:0]} : val;
    endtask

    task automatic push_req(input t_lookup_req r);
        request_q.insert(request_q.size(), r);
        beats_pushed++;
    endtask

    task automatic push_write(input logic [1:0] tsel, input logic [1:0] axis,
                              input logic [11:0] addr, input logic [31:0] val);
        t_lookup_req r;
        r.req = gzl_pkg::REQ_WRITE;
        r.tsel = tsel;
        r.axis = axis;
        r.addr = addr;
        r.wval = val;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        push_req(r);
    endtask

    task automatic push_query(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        t_lookup_req r;
        r.req = gzl_pkg::REQ_QUERY;
        r.tsel = 2'($urandom);
        r.axis = 2'($urandom);
        r.addr = 12'($urandom);
        r.wval = $urandom;
        r.px = x;
        r.py = y;
        r.pz = z;
        push_req(r);
    endtask

    task automatic wait_idle();
        while (beats_accepted != beats_pushed) @(posedge i_clk);
        while (zone_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(input logic [2:0] lo_reg, input logic [2:0] hi_reg);
        longint lo;
        longint hi;
        longint w;
        int     r;
        lo = $signed(cfg_regs[lo_reg]);
        hi = $signed(cfg_regs[hi_reg]);
        w = hi - lo;
        r = $urandom_range(99);
        if (r < 70 && w >= 0) begin
            return 32'(lo + longint'($urandom) % (w + 1));
        end
        if (r < 82) begin
            case ($urandom_range(3))
                0: return 32'(lo);
                1: return 32'(hi);
                2: return 32'(lo - 1);
                default: return 32'(hi + 1);
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_intervals(input int top);
        int near_top;
        near_top = (top < 8) ? top : 8;
        case ($urandom_range(3))
            0: return 32'd1;
            1: return 32'(top);
            2: return 32'($urandom_range(1, near_top));
            default: return 32'($urandom_range(1, top));
        endcase
    endfunction

    task automatic load_tables();
        logic [31:0] val;
        for (int a = 0; a < 3; a++) begin
            for (int e = 0; e < EDGES_USED; e++) begin
                push_write(gzl_pkg::TSEL_EDGE, 2'(a), 12'(e), $urandom);
            end
            for (int c = 0; c < CELLS_USED; c++) begin
                val = $urandom;
                val[5:0] = 6'($urandom_range(IV_REACH - 1));
                push_write(gzl_pkg::TSEL_CELL, 2'(a), 12'(c), val);
            end
            push_write(gzl_pkg::TSEL_SCALE, 2'(a), 12'($urandom), $urandom);
        end
        for (int z = 0; z < ZONES_USED; z++) begin
            val = $urandom;
            val[6] = ($urandom_range(9) < 8);
            push_write(gzl_pkg::TSEL_ZONE, 2'($urandom), 12'(z), val);
        end
    endtask

    task automatic run_directed();
        // reset map is the single point at the origin
        push_query(32'h0, 32'h0, 32'h0);
        push_query(32'h1, 32'h0, 32'h0);
        push_query(32'h0, 32'hFFFFFFFF, 32'h0);
        push_query(32'h0, 32'h0, 32'h1);
        wait_idle();
        for (int a = 0; a < 3; a++) begin
            apb_write(LOW_REG[a], 32'h80000000);
            apb_write(HIGH_REG[a], 32'h7FFFFFFF);
        end
        apb_write(gzl_pkg::REG_Y_IVS, 32'd63);
        apb_write(gzl_pkg::REG_Z_IVS, 32'd63);
        // saturate the x cell index, pin y and z to cell zero
        push_write(gzl_pkg::TSEL_SCALE, AXIS_X, 12'h000, 32'hFFFFFFFF);
        push_write(gzl_pkg::TSEL_SCALE, AXIS_Y, 12'hFFF, 32'h0);
        push_write(gzl_pkg::TSEL_SCALE, AXIS_Z, 12'h5A5, 32'h0);
        // last interval has no upper edge, dense index runs past the table
        push_write(gzl_pkg::TSEL_CELL, AXIS_X, 12'(N_CELLS - 1), 32'd63);
        push_query(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        push_write(gzl_pkg::TSEL_CELL, AXIS_X, 12'h0, 32'h0);
        push_write(gzl_pkg::TSEL_CELL, AXIS_Y, 12'h0, 32'h0);
        push_write(gzl_pkg::TSEL_CELL, AXIS_Z, 12'h0, 32'hFFFFFFC0);
        push_write(gzl_pkg::TSEL_EDGE, AXIS_X, 12'h1, 32'h7FFFFFFF);
        push_write(gzl_pkg::TSEL_EDGE, AXIS_Y, 12'h1, 32'h7FFFFFFF);
        push_write(gzl_pkg::TSEL_EDGE, AXIS_Z, 12'h1, 32'h7FFFFFFF);
        // entry without the present bit reads as empty
        push_write(gzl_pkg::TSEL_ZONE, AXIS_X, 12'h0, 32'h15);
        push_query(32'h80000000, 32'h80000000, 32'h80000000);
        push_write(gzl_pkg::TSEL_ZONE, AXIS_NONE, 12'h0, 32'hFFFFFF7F);
        push_query(32'h80000000, 32'h80000000, 32'h80000000);
        // writes to nonexistent targets must leave the tables alone
        push_write(gzl_pkg::TSEL_EDGE, AXIS_NONE, 12'h0, 32'h0);
        push_write(gzl_pkg::TSEL_CELL, AXIS_X, 12'(N_CELLS), 32'h3F);
        push_write(gzl_pkg::TSEL_EDGE, AXIS_Y, 12'(N_EDGES), 32'h0);
        push_write(gzl_pkg::TSEL_SCALE, AXIS_NONE, 12'h0, 32'hFFFFFFFF);
        push_query(32'h80000000, 32'h80000000, 32'h80000000);
        push_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        wait_idle();
    endtask

    task automatic configure_map(input int kind);
        longint lo;
        longint w;
        longint s;
        logic [31:0] ny;
        logic [31:0] nz;
        for (int a = 0; a < 3; a++) begin
            lo = longint'($urandom_range(32'h80000000, 0)) - longint'(32'h40000000);
            w = (longint'(1) << $urandom_range(4, 29)) + longint'($urandom_range(1000));
            case (kind)
                0: begin
                    lo = longint'(32'sh80000000);
                    w = longint'(32'hFFFFFFFF);
                end
                2: begin
                    if (a == 0) begin
                        w = -longint'($urandom_range(1, 1000));
                    end
                end
                3: begin
                    w = longint'($urandom_range(3));
                end
                default: begin
                end
            endcase
            apb_write(LOW_REG[a], 32'(lo));
            apb_write(HIGH_REG[a], 32'(lo + w));
            // spread the box over the loaded cells, sometimes coarser or finer
            s = (longint'(CELLS_USED / 2) << gzl_pkg::SCALE_FRACTION_BITS)
              / ((w < 0) ? longint'(1) : w + 1);
            case ($urandom_range(3))
                1: s = s * 2;
                2: s = s / 4;
                default: begin
                end
            endcase
            if (s > longint'(32'hFFFFFFFF)) begin
                s = longint'(32'hFFFFFFFF);
            end
            scale_base[a] = 32'(s);
        end
        ny = (kind == 0) ? 32'd1 : pick_intervals(63);
        nz = (kind == 0) ? 32'd63 : pick_intervals(ZONE_PAIRS / (int'(ny) + 1));
        apb_write(gzl_pkg::REG_Y_IVS, ny);
        apb_write(gzl_pkg::REG_Z_IVS, nz);
        for (int a = 0; a < 3; a++) begin
            push_write(gzl_pkg::TSEL_SCALE, 2'(a), 12'($urandom), scale_base[a]);
        end
    endtask

    task automatic run_random(input int count);
        logic [1:0]  tsel;
        logic [1:0]  axis;
        logic [11:0] addr;
        logic [31:0] val;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85) begin
                push_query(pick_coord(gzl_pkg::REG_X_LOW, gzl_pkg::REG_X_HIGH),
                           pick_coord(gzl_pkg::REG_Y_LOW, gzl_pkg::REG_Y_HIGH),
                           pick_coord(gzl_pkg::REG_Z_LOW, gzl_pkg::REG_Z_HIGH));
            end else begin
                tsel = 2'($urandom);
                axis = ($urandom_range(9) == 0) ? AXIS_NONE : 2'($urandom_range(2));
                addr = 12'($urandom);
                val = $urandom;
                case (tsel)
                    gzl_pkg::TSEL_EDGE: begin
                        if ($urandom_range(9) != 0) begin
                            addr = 12'($urandom_range(N_EDGES - 1));
                        end
                    end
                    gzl_pkg::TSEL_CELL: begin
                        if ($urandom_range(9) != 0) begin
                            addr = 12'($urandom_range(N_CELLS - 1));
                        end
                        val[5:0] = 6'($urandom_range(IV_REACH - 1));
                    end
                    gzl_pkg::TSEL_SCALE: begin
                        // keep every in-box offset inside the loaded cells
                        if (axis != AXIS_NONE) begin
                            val = scale_base[axis] >> $urandom_range(2);
                        end
                    end
                    default: begin
                    end
                endcase
                push_write(tsel, axis, addr, val);
            end
        end
    endtask

    initial begin : stimulus
        for (int r = 0; r < 8; r++) begin
            cfg_regs[r] = '0;
        end
        cfg_regs[gzl_pkg::REG_Y_IVS] = 32'd1;
        cfg_regs[gzl_pkg::REG_Z_IVS] = 32'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_tables();
        run_directed();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int k = 0; k < 2; k++) begin
                configure_map((2 * p + k) % 5);
                if (p == 0 && k == 0) begin
                    holds_asked++;
                end
                run_random(RANDOM_BEATS);
                wait_idle();
            end
        end
        if (zone_results_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, zone_results_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gzl_pkg.sv
rtl/gzl_axis.sv
rtl/grid_zone_lookup_3d.sv
test/tb_top.sv
